[sv/ocn_pkg.sv]
// Package for the overbright color normalizer.
// Holds channel widths, the shift reset value, the stage-load struct and the
// restoring-division step shared by the lanes. No dependencies.
`default_nettype none

package ocn_pkg;

  localparam int CHAN_W  = 8;
  localparam int SHIFT_W = 3;
  localparam int WIDE_W  = CHAN_W + (1 << SHIFT_W) - 1;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;
  localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'd255;

  typedef struct packed {
    logic ld_div;
    logic ld_fin;
    logic ld_out;
  } ocn_ctl_t;

  // One restoring step: {quotient bit, new remainder}
  function automatic logic [CHAN_W:0] div_step(input logic [CHAN_W-1:0] rem,
                                               input logic              nbit,
                                               input logic [CHAN_W-1:0] d);
    logic [CHAN_W:0] r2;
    logic [CHAN_W:0] diff;
    r2   = {rem, nbit};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      div_step = {1'b1, diff[CHAN_W-1:0]};
    end else begin
      div_step = {1'b0, r2[CHAN_W-1:0]};
    end
  endfunction

endpackage

`default_nettype wire

[sv/overbright_color_normalize.sv]
// Overbright color normalizer top level: input register, merge, three lanes.
// Stages: input register, two divider stages, output register. Throughput is one
// pixel per cycle unless out_stall holds; lane divider stages are fully pipelined.
// Reset (rst, synchronous): all stage valids cleared, overbright_shift = 3.
// cfg_ready is always high. Depends on ocn_pkg, ocn_merge, ocn_lane.
`default_nettype none

module overbright_color_normalize (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ocn_pkg::SHIFT_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [ocn_pkg::CHAN_W-1:0]  in_red,
  input  wire logic [ocn_pkg::CHAN_W-1:0]  in_green,
  input  wire logic [ocn_pkg::CHAN_W-1:0]  in_blue,
  input  wire logic [ocn_pkg::CHAN_W-1:0]  in_alpha,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [ocn_pkg::CHAN_W-1:0]  out_red,
  output logic      [ocn_pkg::CHAN_W-1:0]  out_green,
  output logic      [ocn_pkg::CHAN_W-1:0]  out_blue,
  output logic      [ocn_pkg::CHAN_W-1:0]  out_alpha
);
  import ocn_pkg::*;

  logic [SHIFT_W-1:0] overbright_shift;

  logic v1, v2, v3;
  logic take1, take2, take3, acc;
  ocn_ctl_t ctl;

  logic [CHAN_W-1:0] r1, g1, b1, a1;
  logic [CHAN_W-1:0] a2, a3;
  logic [CHAN_W-1:0] div2, div3;
  logic              norm2, norm3;
  logic [CHAN_W-1:0] max_chan;
  logic              norm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      overbright_shift <= SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      overbright_shift <= cfg_data;
    end
  end

  // pipeline handshake, bubbles collapse
  always_comb begin
    take3      = v3 && (!out_valid || !out_stall);
    take2      = v2 && (!v3 || take3);
    take1      = v1 && (!v2 || take2);
    in_stall   = v1 && !take1;
    acc        = in_valid && !in_stall;
    ctl.ld_div = take1;
    ctl.ld_fin = take2;
    ctl.ld_out = take3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        v1 <= 1'b1;
      end else if (take1) begin
        v1 <= 1'b0;
      end
      if (take1) begin
        v2 <= 1'b1;
      end else if (take2) begin
        v2 <= 1'b0;
      end
      if (take2) begin
        v3 <= 1'b1;
      end else if (take3) begin
        v3 <= 1'b0;
      end
      if (take3) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      r1 <= in_red;
      g1 <= in_green;
      b1 <= in_blue;
      a1 <= in_alpha;
    end
    if (take1) begin
      a2    <= a1;
      div2  <= max_chan;
      norm2 <= norm;
    end
    if (take2) begin
      a3    <= a2;
      div3  <= div2;
      norm3 <= norm2;
    end
    if (take3) begin
      out_alpha <= a3;
    end
  end

  ocn_merge u_merge (
    .red      (r1),
    .green    (g1),
    .blue     (b1),
    .shift    (overbright_shift),
    .max_chan (max_chan),
    .norm     (norm)
  );

  ocn_lane u_lane_red (
    .clk    (clk),
    .ctl    (ctl),
    .chan   (r1),
    .shift  (overbright_shift),
    .div_a  (div2),
    .div_b  (div3),
    .norm_b (norm3),
    .result (out_red)
  );

  ocn_lane u_lane_green (
    .clk    (clk),
    .ctl    (ctl),
    .chan   (g1),
    .shift  (overbright_shift),
    .div_a  (div2),
    .div_b  (div3),
    .norm_b (norm3),
    .result (out_green)
  );

  ocn_lane u_lane_blue (
    .clk    (clk),
    .ctl    (ctl),
    .chan   (b1),
    .shift  (overbright_shift),
    .div_a  (div2),
    .div_b  (div3),
    .norm_b (norm3),
    .result (out_blue)
  );

  // normalize implies a nonzero divisor
  a_norm_div: assert property (@(posedge clk) disable iff (rst)
    v3 && norm3 |-> div3 != '0)
    else $error("normalize with zero divisor");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1)
    else $error("input stalled with empty first stage");

  a_acc_fill: assert property (@(posedge clk) disable iff (rst)
    acc |=> v1)
    else $error("accepted pixel lost at first stage");

  a_take_out: assert property (@(posedge clk) disable iff (rst)
    take3 |=> out_valid)
    else $error("pixel lost at output stage");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> overbright_shift == $past(cfg_data))
    else $error("config transfer not stored");

endmodule

`default_nettype wire

[sv/ocn_merge.sv]
// Merge stage: largest color channel across the lanes and the normalize flag.
// Depends on ocn_pkg.
`default_nettype none

module ocn_merge (
  input  wire logic [ocn_pkg::CHAN_W-1:0]  red,
  input  wire logic [ocn_pkg::CHAN_W-1:0]  green,
  input  wire logic [ocn_pkg::CHAN_W-1:0]  blue,
  input  wire logic [ocn_pkg::SHIFT_W-1:0] shift,
  output logic      [ocn_pkg::CHAN_W-1:0]  max_chan,
  output logic                             norm
);
  import ocn_pkg::*;

  logic [CHAN_W-1:0] max_rg;
  logic [WIDE_W-1:0] max_wide;

  always_comb begin
    max_rg   = (red > green) ? red : green;
    max_chan = (max_rg > blue) ? max_rg : blue;
    max_wide = WIDE_W'(max_chan) << shift;
    norm     = max_wide > WIDE_W'(CHAN_MAX);
  end

endmodule

`default_nettype wire

[sv/ocn_lane.sv]
// One color lane: shifted pass value and c*255/max by a two-stage
// restoring divider, four quotient bits per stage. Depends on ocn_pkg.
`default_nettype none

module ocn_lane (
  input  wire logic                       clk,
  input  wire ocn_pkg::ocn_ctl_t          ctl,
  input  wire logic [ocn_pkg::CHAN_W-1:0]  chan,
  input  wire logic [ocn_pkg::SHIFT_W-1:0] shift,
  input  wire logic [ocn_pkg::CHAN_W-1:0]  div_a,
  input  wire logic [ocn_pkg::CHAN_W-1:0]  div_b,
  input  wire logic                        norm_b,
  output logic      [ocn_pkg::CHAN_W-1:0]  result
);
  import ocn_pkg::*;

  localparam int HALF = CHAN_W / 2;

  logic [2*CHAN_W-1:0] num;
  logic [WIDE_W-1:0]   wide;

  logic [CHAN_W-1:0] rem_a;
  logic [CHAN_W-1:0] low_a;
  logic [CHAN_W-1:0] pass_a;

  logic [CHAN_W-1:0] rem_b;
  logic [HALF-1:0]   low_b;
  logic [HALF-1:0]   qhi_b;
  logic [CHAN_W-1:0] pass_b;

  logic [CHAN_W-1:0] ra;
  logic [HALF-1:0]   qa;
  logic [CHAN_W:0]   sa;
  logic [CHAN_W-1:0] rb;
  logic [HALF-1:0]   qb;
  logic [CHAN_W:0]   sb;

  always_comb begin
    num  = (2*CHAN_W)'(chan) * (2*CHAN_W)'(CHAN_MAX);
    wide = WIDE_W'(chan) << shift;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_div) begin
      rem_a  <= num[2*CHAN_W-1:CHAN_W];
      low_a  <= num[CHAN_W-1:0];
      pass_a <= wide[CHAN_W-1:0];
    end
  end

  // upper quotient bits
  always_comb begin
    ra = rem_a;
    qa = '0;
    sa = '0;
    for (int i = 0; i < HALF; i++) begin
      sa = div_step(ra, low_a[CHAN_W-1-i], div_a);
      qa[HALF-1-i] = sa[CHAN_W];
      ra = sa[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_fin) begin
      rem_b  <= ra;
      low_b  <= low_a[HALF-1:0];
      qhi_b  <= qa;
      pass_b <= pass_a;
    end
  end

  // lower quotient bits
  always_comb begin
    rb = rem_b;
    qb = '0;
    sb = '0;
    for (int i = 0; i < HALF; i++) begin
      sb = div_step(rb, low_b[HALF-1-i], div_b);
      qb[HALF-1-i] = sb[CHAN_W];
      rb = sb[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      result <= norm_b ? {qhi_b, qb} : pass_b;
    end
  end

endmodule

`default_nettype wire

[tb/ocn_checker.sv]
// Checker for the overbright color normalizer: watches the config, input and
// output channels, predicts each output pixel and compares it field by field.
// Depends on ocn_pkg for widths and the shift reset value.
`timescale 1ns / 1ps

module ocn_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [ocn_pkg::SHIFT_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [ocn_pkg::CHAN_W-1:0]  in_red,
  input  logic [ocn_pkg::CHAN_W-1:0]  in_green,
  input  logic [ocn_pkg::CHAN_W-1:0]  in_blue,
  input  logic [ocn_pkg::CHAN_W-1:0]  in_alpha,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [ocn_pkg::CHAN_W-1:0]  out_red,
  input  logic [ocn_pkg::CHAN_W-1:0]  out_green,
  input  logic [ocn_pkg::CHAN_W-1:0]  out_blue,
  input  logic [ocn_pkg::CHAN_W-1:0]  out_alpha,
  output int                          err_count,
  output int                          pending
);
  import ocn_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  pixel_t             pixel_q[$];
  logic [SHIFT_W-1:0] cur_shift = SHIFT_RESET;
  int                 fails     = 0;

  function automatic pixel_t overbright_predict(pixel_t px, logic [SHIFT_W-1:0] sh);
    logic [WIDE_W-1:0] r;
    logic [WIDE_W-1:0] g;
    logic [WIDE_W-1:0] b;
    logic [WIDE_W-1:0] peak;
    pixel_t            res;
    r = WIDE_W'(px.red) << sh;
    g = WIDE_W'(px.green) << sh;
    b = WIDE_W'(px.blue) << sh;
    res.alpha = px.alpha;
    if (r > CHAN_MAX || g > CHAN_MAX || b > CHAN_MAX) begin
      peak = (r > g) ? r : g;
      peak = (peak > b) ? peak : b;
      res.red   = CHAN_W'((int'(r) * int'(CHAN_MAX)) / int'(peak));
      res.green = CHAN_W'((int'(g) * int'(CHAN_MAX)) / int'(peak));
      res.blue  = CHAN_W'((int'(b) * int'(CHAN_MAX)) / int'(peak));
    end else begin
      res.red   = r[CHAN_W-1:0];
      res.green = g[CHAN_W-1:0];
      res.blue  = b[CHAN_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    pixel_t inp;
    if (rst) begin
      cur_shift = SHIFT_RESET;
      pixel_q.delete();
      fails = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_red, out_green, out_blue, out_alpha};
        if (pixel_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: output transfer with nothing pending: %h", $realtime, got);
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch exp r=%0d g=%0d b=%0d a=%0d got r=%0d g=%0d b=%0d a=%0d",
                       $realtime, want.red, want.green, want.blue, want.alpha,
                       got.red, got.green, got.blue, got.alpha);
          end
        end
      end
      if (in_valid && !in_stall) begin
        inp     = '{in_red, in_green, in_blue, in_alpha};
        pixel_q = {pixel_q, overbright_predict(inp, cur_shift)};
      end
      if (cfg_valid && cfg_ready)
        cur_shift = cfg_data;
    end
    err_count <= fails;
    pending   <= pixel_q.size();
  end

endmodule

[tb/overbright_color_normalize_tb.sv]
// Testbench top for the overbright color normalizer: clock, reset, stimulus
// with random gaps and stalls, config phases, watchdog and verdict.
// Depends on ocn_pkg, overbright_color_normalize and ocn_checker.
`timescale 1ns / 1ps

module overbright_color_normalize_tb;
  import ocn_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [SHIFT_W-1:0] cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [CHAN_W-1:0]  in_red    = '0;
  logic [CHAN_W-1:0]  in_green  = '0;
  logic [CHAN_W-1:0]  in_blue   = '0;
  logic [CHAN_W-1:0]  in_alpha  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAN_W-1:0]  out_red;
  logic [CHAN_W-1:0]  out_green;
  logic [CHAN_W-1:0]  out_blue;
  logic [CHAN_W-1:0]  out_alpha;

  logic steady     = 1'b0;
  int   fail_cnt;
  int   pending_cnt;
  int   stall_hold = 0;
  int   quiet      = 0;

  always #10 clk = ~clk;

  overbright_color_normalize u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .in_alpha (in_alpha),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue),
    .out_alpha(out_alpha)
  );

  ocn_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .in_alpha (in_alpha),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue),
    .out_alpha(out_alpha),
    .err_count(fail_cnt),
    .pending  (pending_cnt)
  );

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk) begin
    if (rst || steady) begin
      out_stall  <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_hold = idle_len();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    in_alpha <= a;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input logic [SHIFT_W-1:0] sh);
    int             lim;
    logic [CHAN_W-1:0] c[3];
    lim = int'(CHAN_MAX) >> sh;
    case ($urandom_range(0, 3))
      0: begin
        foreach (c[i]) c[i] = CHAN_W'($urandom_range(0, 255));
      end
      1: begin
        foreach (c[i]) c[i] = CHAN_W'($urandom_range(0, lim));
      end
      2: begin
        foreach (c[i]) c[i] = CHAN_W'($urandom_range(0, lim));
        c[$urandom_range(0, 2)] = CHAN_W'($urandom_range(0, 255));
      end
      default: begin
        foreach (c[i])
          case ($urandom_range(0, 3))
            0:       c[i] = '0;
            1:       c[i] = CHAN_MAX;
            2:       c[i] = CHAN_W'(lim + $urandom_range(0, 1));
            default: c[i] = CHAN_W'($urandom_range(0, 255));
          endcase
      end
    endcase
    send_pixel(c[0], c[1], c[2], CHAN_W'($urandom_range(0, 255)));
  endtask

  // only while nothing is in flight
  task automatic write_shift(input logic [SHIFT_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [SHIFT_W-1:0] sh;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset shift of 3
    send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0,   8'h80);
    send_pixel(8'd0,   8'd255, 8'd0,   8'h01);
    send_pixel(8'd0,   8'd0,   8'd255, 8'hFE);
    send_pixel(8'd31,  8'd31,  8'd31,  8'h55);
    send_pixel(8'd32,  8'd0,   8'd0,   8'hAA);
    send_pixel(8'd31,  8'd32,  8'd1,   8'h07);
    send_pixel(8'd1,   8'd2,   8'd3,   8'h00);

    write_shift(3'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd0,   8'd255);
    send_pixel(8'd128, 8'd64,  8'd1,   8'd3);

    write_shift(3'd7);
    send_pixel(8'd255, 8'd1,   8'd0,   8'd9);
    send_pixel(8'd1,   8'd1,   8'd1,   8'd0);
    send_pixel(8'd2,   8'd1,   8'd0,   8'd0);
    send_pixel(8'd1,   8'd0,   8'd1,   8'd255);
    send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd128, 8'h0F);

    for (int ph = 0; ph < 16; ph++) begin
      sh = (ph < 8) ? SHIFT_W'(7 - ph) : SHIFT_W'($urandom_range(0, 7));
      if (ph == 15) sh = 3'd7;
      steady <= (ph % 5 == 2);
      write_shift(sh);
      repeat (90) send_random(sh);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
